/* rtl/core/fpadd_pkg.sv */
// Shared types and constants for the binary32 adder pipeline.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none
package fpadd_pkg;
  localparam int unsigned ExpW = 8;
  localparam int unsigned AccW = 28;
  localparam logic [ExpW-1:0] ExpAllOnes = 8'hFF;

  typedef struct packed {
    logic        sign;
    logic [8:0]  exp;
    logic [AccW-1:0] acc;
    logic        not_real;
  } fpadd_mid_t;

  typedef struct packed {
    logic [31:0] sum_bits;
    logic        not_real;
    logic        overflowed;
  } fpadd_res_t;

  function automatic logic [4:0] fpadd_lzc(input logic [AccW-1:0] a);
    logic [4:0] n;
    logic       hit;
    n = 5'd27;
    hit = 1'b0;
    for (int i = AccW - 2; i >= 0; i--) begin
      if (!hit && a[i]) begin
        n = 5'(AccW - 2 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/fpadd_align.sv */
// First stage: operand swap, special detection, significand alignment and the add.
// Depends on fpadd_pkg.
`default_nettype none
module fpadd_align import fpadd_pkg::*; (
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output fpadd_mid_t       mid_o
);
  logic [31:0] big, sml;
  logic [8:0]  eb, es, ex_gap;
  logic [AccW-1:0] wb, ws, sh, lostm;
  logic nr;

  always_comb begin
    nr = (operand_a_i[30:23] == ExpAllOnes) || (operand_b_i[30:23] == ExpAllOnes);
    if (operand_a_i[30:0] >= operand_b_i[30:0]) begin
      big = operand_a_i; sml = operand_b_i;
    end else begin
      big = operand_b_i; sml = operand_a_i;
    end
    eb = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
    es = (sml[30:23] == 8'd0) ? 9'd1 : {1'b0, sml[30:23]};
    wb = {1'b0, (big[30:23] != 8'd0), big[22:0], 3'b000};
    ws = {1'b0, (sml[30:23] != 8'd0), sml[22:0], 3'b000};
    ex_gap = eb - es;
    lostm = '0;
    if (ex_gap >= 9'd27) begin
      sh = {27'd0, (ws != '0)};
    end else begin
      lostm = ~({AccW{1'b1}} << ex_gap[4:0]);
      sh = (ws >> ex_gap[4:0]) | {27'd0, ((ws & lostm) != '0)};
    end
    mid_o.sign = big[31];
    mid_o.exp = eb;
    mid_o.acc = (big[31] == sml[31]) ? wb + sh : wb - sh;
    mid_o.not_real = nr;
  end
endmodule
`default_nettype wire

/* rtl/core/fpadd_norm.sv */
// Second stage: carry handling and leading-zero normalization shift.
// Depends on fpadd_pkg.
`default_nettype none
module fpadd_norm import fpadd_pkg::*; (
  input  wire fpadd_mid_t mid_i,
  output fpadd_mid_t mid_o
);
  logic [4:0] lz, amt;
  always_comb begin
    mid_o = mid_i;
    amt = '0;
    lz = fpadd_lzc(mid_i.acc);
    if (mid_i.acc[AccW-1]) begin
      mid_o.acc = (mid_i.acc >> 1) | {27'd0, mid_i.acc[0]};
      mid_o.exp = mid_i.exp + 9'd1;
    end else begin
      amt = ({4'd0, lz} < mid_i.exp - 9'd1) ? lz : 5'(mid_i.exp - 9'd1);
      mid_o.acc = mid_i.acc << amt;
      mid_o.exp = mid_i.exp - {4'd0, amt};
    end
  end
endmodule
`default_nettype wire

/* rtl/core/fpadd_round.sv */
// Third stage: round to nearest even, overflow and special result packing.
// Depends on fpadd_pkg.
`default_nettype none
module fpadd_round import fpadd_pkg::*; (
  input  wire fpadd_mid_t mid_i,
  output fpadd_res_t res_o
);
  logic [24:0] fr;
  logic [8:0]  ex;
  always_comb begin
    fr = {1'b0, mid_i.acc[26:3]};
    if (mid_i.acc[2] && ((mid_i.acc[1:0] != 2'b00) || mid_i.acc[3])) fr = fr + 25'd1;
    ex = mid_i.exp;
    if (fr[24]) begin
      fr = fr >> 1;
      ex = ex + 9'd1;
    end
    res_o = '0;
    if (mid_i.not_real) begin
      res_o.not_real = 1'b1;
    end else if (mid_i.acc == '0) begin
      res_o.sum_bits = '0;
    end else if (ex >= 9'd255) begin
      res_o.sum_bits = {mid_i.sign, ExpAllOnes, 23'd0};
      res_o.overflowed = 1'b1;
    end else begin
      res_o.sum_bits = {mid_i.sign, (fr[23] ? ex[7:0] : 8'd0), fr[22:0]};
    end
  end
endmodule
`default_nettype wire

/* rtl/core/fp32_adder_round_nearest_even.sv */
// Top level of the pipelined binary32 adder with valid/stall handshake.
// Depends on fpadd_pkg, fpadd_align, fpadd_norm and fpadd_round.
// A beat can enter every cycle in which in_stall_o is low. Its result
// passes through one register stage each for alignment with add,
// normalization, and rounding before it is valid on the output. A stall on
// the output freezes the stages that hold beats; an empty stage lets the
// stages before it move up.
`default_nettype none
module fp32_adder_round_nearest_even import fpadd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      sum_bits_o,
  output logic             not_real_input_o,
  output logic             overflowed_o
);
  fpadd_mid_t a_d, a_q, n_d, n_q;
  fpadd_res_t r_d, r_q;
  logic v1_q, v2_q, v3_q, en1, en2, en3;

  fpadd_align u_align (.operand_a_i, .operand_b_i, .mid_o(a_d));
  fpadd_norm  u_norm  (.mid_i(a_q), .mid_o(n_d));
  fpadd_round u_round (.mid_i(n_q), .res_o(r_d));

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) a_q <= a_d;
    if (en2) n_q <= n_d;
    if (en3) r_q <= r_d;
  end

  assign out_valid_o = v3_q;
  assign sum_bits_o = r_q.sum_bits;
  assign not_real_input_o = r_q.not_real;
  assign overflowed_o = r_q.overflowed;

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && r_q.not_real |-> r_q.sum_bits == 32'd0 && !r_q.overflowed)
    else $error("special flag with nonzero sum");
  a_ovf_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && r_q.overflowed |-> r_q.sum_bits[30:0] == 31'h7F800000)
    else $error("overflow without infinity");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q)
    else $error("stage two beat lost");
endmodule
`default_nettype wire

/* test/fp32_adder_round_nearest_even_tb.sv */
// Testbench for the binary32 round-to-nearest-even adder with valid/stall beats.
// Depends on fpadd_pkg and fp32_adder_round_nearest_even; a scoreboard class
// predicts each sum and checks results in order.
`timescale 1ns / 1ps
module fp32_adder_round_nearest_even_tb;
  import fpadd_pkg::*;

  class sum_scoreboard;
    fpadd_res_t pending_sums[$];
    int mismatches;

    function fpadd_res_t predict_sum(logic [31:0] pa, logic [31:0] pb);
      fpadd_res_t r;
      logic [31:0] big, sml, acc, wb, ws, fo;
      logic sgb, sgs;
      int eb, es, ex_gap, er;
      r = '0;
      if (pa[30:23] == ExpAllOnes || pb[30:23] == ExpAllOnes) begin
        r.not_real = 1'b1;
        return r;
      end
      if (pa[30:0] >= pb[30:0]) begin
        big = pa;
        sml = pb;
      end else begin
        big = pb;
        sml = pa;
      end
      sgb = big[31];
      sgs = sml[31];
      eb = (big[30:23] == 0) ? 1 : big[30:23];
      es = (sml[30:23] == 0) ? 1 : sml[30:23];
      wb = {5'd0, big[30:23] != 0, big[22:0], 3'd0};
      ws = {5'd0, sml[30:23] != 0, sml[22:0], 3'd0};
      ex_gap = eb - es;
      if (ex_gap >= 27) begin
        ws = (ws != 0) ? 32'd1 : 32'd0;
      end else if (ex_gap > 0) begin
        ws = (ws >> ex_gap) | {31'd0, ((ws & ((32'd1 << ex_gap) - 32'd1)) != 0)};
      end
      acc = (sgb == sgs) ? wb + ws : wb - ws;
      if (acc == 0) return r;
      er = eb;
      if (acc[27]) begin
        acc = (acc >> 1) | {31'd0, acc[0]};
        er++;
      end else begin
        while (!acc[26] && er > 1) begin
          acc = acc << 1;
          er--;
        end
      end
      fo = acc >> 3;
      if (acc[2] && (acc[1:0] != 0 || acc[3])) fo++;
      if (fo[24]) begin
        fo = fo >> 1;
        er++;
      end
      if (er >= 255) begin
        r.sum_bits = {sgb, 8'hFF, 23'd0};
        r.overflowed = 1'b1;
        return r;
      end
      r.sum_bits = {sgb, fo[23] ? 8'(er) : 8'd0, fo[22:0]};
      return r;
    endfunction

    function void note_operands(logic [31:0] pa, logic [31:0] pb);
      pending_sums.push_back(predict_sum(pa, pb));
    endfunction

    function void check_sum(fpadd_res_t got);
      fpadd_res_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got.sum_bits);
        return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %h nr=%b ov=%b, got %h nr=%b ov=%b",
                   want.sum_bits, want.not_real, want.overflowed,
                   got.sum_bits, got.not_real, got.overflowed);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] sum_bits_o;
  logic not_real_input_o;
  logic overflowed_o;
  int send_idle_pct = 0;
  int stall_pct = 0;
  sum_scoreboard sb = new();

  fp32_adder_round_nearest_even dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_sum('{sum_bits: sum_bits_o, not_real: not_real_input_o,
                     overflowed: overflowed_o});
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_operands(logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_operands(a, b);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_float();
    logic [7:0] e;
    case ($urandom_range(7))
      0: e = 8'd0;
      1: e = 8'hFF;
      2: e = 8'(8'hFE - $urandom_range(3));
      3: e = 8'($urandom_range(1, 4));
      default: e = 8'($urandom_range(90, 165));
    endcase
    return {1'($urandom), e, 23'($urandom)};
  endfunction

  function automatic logic [31:0] near_operand(logic [31:0] a);
    logic [31:0] b;
    b = random_float();
    case ($urandom_range(3))
      0: b = {~a[31], a[30:0]};
      1: b = {~a[31], a[30:4], 4'($urandom)};
      2: b = {b[31], 8'(a[30:23] - $urandom_range(30)), b[22:0]};
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    logic [31:0] directed_a[$], directed_b[$], a;
    directed_a = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F7F_FFFF,
                   32'hFF7F_FFFF, 32'h7F80_0000, 32'h7FC0_0000, 32'h3F80_0000,
                   32'h007F_FFFF, 32'h0000_0001, 32'h0080_0000, 32'h3F80_0000,
                   32'h3F80_0000, 32'hFFFF_FFFF, 32'h4B80_0000, 32'h0040_0000};
    directed_b = '{32'h0000_0000, 32'h8000_0000, 32'hBF80_0000, 32'h7F7F_FFFF,
                   32'hFF7F_FFFF, 32'h3F80_0000, 32'h0000_0000, 32'h3380_0000,
                   32'h0000_0001, 32'h8000_0001, 32'h8000_0001, 32'h33C0_0000,
                   32'h3F80_0001, 32'h0000_0000, 32'h3F80_0000, 32'h0040_0000};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_a[i]) send_operands(directed_a[i], directed_b[i]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 15) : 0;
      stall_pct = (ph == 2) ? 46 : ((ph == 3) ? 15 : 0);
      for (int i = 0; i < 225; i++) begin
        a = random_float();
        send_operands(a, near_operand(a));
      end
    end
    in_valid_i <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
